// ===== hdl/mtk_pkg.sv =====
package mtk_pkg;

  localparam logic [7:0] BACKSPACE_CODE = 8'd8;
  localparam int         ROM_KEYS       = 16;
  localparam int         ROM_SLOTS      = 8;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_PRESS   = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_DOUBLE_TAP = 2'd1,
    REG_HOLD       = 2'd2,
    REG_REPEAT     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] double_tap_ticks;
    logic [15:0] hold_ticks;
    logic [15:0] repeat_latency_ticks;
  } cfg_t;

  // One queued message: when two is set, a backspace goes out ahead of code.
  typedef struct packed {
    logic       two;
    logic [7:0] code;
    logic       press;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_push_t;

  typedef struct packed {
    logic valid;
    logic full;
    job_t job;
  } q_stat_t;

  localparam logic [7:0] KEY_ROM [ROM_KEYS][ROM_SLOTS] = '{
    '{8'd17, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd19, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd18, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{8'd16, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"3", "D", "E", "F", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"6", "M", "N", "O", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"9", "W", "X", "Y", "Z", 8'd0, 8'd0, 8'd0},
    '{8'd13, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"2", "A", "B", "C", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"5", "J", "K", "L", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"8", "T", "U", "V", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"0", " ", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"1", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"4", "G", "H", "I", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"7", "P", "Q", "R", "S", 8'd0, 8'd0, 8'd0},
    '{8'd30, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
  };

  localparam logic [3:0] KEY_LEN [ROM_KEYS] = '{
    4'd1, 4'd1, 4'd1, 4'd1, 4'd4, 4'd4, 4'd5, 4'd1,
    4'd4, 4'd4, 4'd4, 4'd2, 4'd1, 4'd4, 4'd5, 4'd1
  };

  // Bit k set: key k is a character key.
  localparam logic [ROM_KEYS-1:0] KEY_IS_CHAR = 16'b0111_1111_0111_0000;

endpackage

// ===== hdl/mtk_in_if.sv =====
interface mtk_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [1:0] key_row;
  logic [1:0] key_col;

  modport source (output valid, output mode, output key_row, output key_col, input ready);
  modport sink   (input valid, input mode, input key_row, input key_col, output ready);
endinterface

// ===== hdl/mtk_out_if.sv =====
interface mtk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_code;
  logic       is_press;
  logic       last_of_run;

  modport source (output valid, output key_code, output is_press, output last_of_run,
                  input ready);
  modport sink   (input valid, input key_code, input is_press, input last_of_run,
                  output ready);
endinterface

// ===== hdl/mtk_cfg_if.sv =====
interface mtk_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/multitap_keypad_entry_unit.sv =====
// Multi-tap keypad entry. Each transfer on keys is a tick, a press or a release of a
// 4x4 keypad key; each transfer on msgs is one key message (code, press flag, and a
// last_of_run flag that marks the final message caused by an input). A character key
// pressed again inside the double-tap window, or held past hold_ticks (then every
// repeat_latency_ticks+1 ticks), sends a backspace and then its next letter; code keys
// repeat their code. Presses within twice debounce_ticks of a release are dropped.
// A front stage takes one input transfer per cycle, updates the key state and queues at
// most one job in a two-entry queue; keys.ready drops only while that queue is full.
// The back stage turns each job into one or two messages, one per cycle unless msgs
// holds back ready, through a registered output; it takes no new job while the second
// message of a pair is pending. An input's job is registered in the queue and its first
// message in the output register. Configuration writes are always taken (cfg.ready
// is tied high) and belong only to idle periods. Times wrap modulo 2^TIME_BITS; no
// clearing pass is needed after reset.
module multitap_keypad_entry_unit #(
  parameter int ROWS        = 4,
  parameter int COLS        = 4,
  parameter int MAX_LETTERS = 5,
  parameter int TIME_BITS   = 32
) (
  input  logic      clk,
  input  logic      rst,
  mtk_in_if.sink    keys,
  mtk_out_if.source msgs,
  mtk_cfg_if.sink   cfg
);

  mtk_pkg::cfg_t    cfg_regs;
  mtk_pkg::q_push_t q_push;
  mtk_pkg::q_stat_t q_stat;
  logic             pop;

  // Configuration registers: take every write, ignore nothing but the data width.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.debounce_ticks       <= 16'd20;
      cfg_regs.double_tap_ticks     <= 16'd800;
      cfg_regs.hold_ticks           <= 16'd1000;
      cfg_regs.repeat_latency_ticks <= 16'd300;
    end else if (cfg.valid) begin
      case (mtk_pkg::cfg_reg_t'(cfg.index))
        mtk_pkg::REG_DEBOUNCE:   cfg_regs.debounce_ticks       <= cfg.data;
        mtk_pkg::REG_DOUBLE_TAP: cfg_regs.double_tap_ticks     <= cfg.data;
        mtk_pkg::REG_HOLD:       cfg_regs.hold_ticks           <= cfg.data;
        mtk_pkg::REG_REPEAT:     cfg_regs.repeat_latency_ticks <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Front: accept, classify, update key state, queue the job.
  mtk_front #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .MAX_LETTERS (MAX_LETTERS),
    .TIME_BITS   (TIME_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .keys     (keys),
    .cfg_regs (cfg_regs),
    .q_stat   (q_stat),
    .q_push   (q_push)
  );

  // Short job queue decoupling the two sides.
  mtk_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .pop    (pop),
    .q_stat (q_stat)
  );

  // Back: expand each job into one or two messages.
  mtk_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .pop    (pop),
    .msgs   (msgs)
  );

`ifndef SYNTHESIS
  // A job is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push.valid |-> !q_stat.full)
    else $error("job pushed into full queue");

  // The first of two messages is always a pressed backspace.
  a_first_is_bs: assert property (@(posedge clk) disable iff (rst)
    (msgs.valid && !msgs.last_of_run) |->
      (msgs.key_code == mtk_pkg::BACKSPACE_CODE && msgs.is_press))
    else $error("non-final message is not a backspace");

  // The second message follows right after the first one is taken.
  a_pair_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (msgs.valid && msgs.ready && !msgs.last_of_run) |=>
      (msgs.valid && msgs.last_of_run && msgs.is_press))
    else $error("second message of a pair missing");
`endif

endmodule

// ===== hdl/mtk_front.sv =====
module mtk_front #(
  parameter int ROWS        = 4,
  parameter int COLS        = 4,
  parameter int MAX_LETTERS = 5,
  parameter int TIME_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  mtk_in_if.sink               keys,
  input  mtk_pkg::cfg_t        cfg_regs,
  input  mtk_pkg::q_stat_t     q_stat,
  output mtk_pkg::q_push_t     q_push
);

  localparam int CMP_W = (TIME_BITS > 17) ? TIME_BITS : 17;

  // Ticks since the last release, and ticks left until the next auto advance.
  logic [TIME_BITS-1:0] since_rel, since_rel_next;
  logic [TIME_BITS-1:0] until_fire, until_fire_next;
  logic                 held, held_next;
  logic [3:0]           cur_key, cur_key_next;
  logic                 rel_valid, rel_valid_next;
  logic [3:0]           rel_key, rel_key_next;
  logic [2:0]           tap, tap_next;

  logic                 accept;
  logic [3:0]           key;
  logic [3:0]           adv_key;
  logic [3:0]           letters;
  logic [3:0]           tap_inc;
  logic [2:0]           tap_adv;
  logic                 adv_char;
  logic                 fire;
  logic                 locked;
  logic                 multi_tap;
  logic [CMP_W-1:0]     since_w;
  logic [CMP_W-1:0]     hold_w;
  logic [CMP_W-1:0]     rep_w;
  logic [3:0]           rom_key;
  logic [2:0]           rom_idx;

  assign keys.ready = !q_stat.full;
  assign accept     = keys.valid && keys.ready;
  assign key        = {keys.key_row, keys.key_col};
  assign since_w    = CMP_W'(since_rel);
  assign hold_w     = CMP_W'({1'b0, cfg_regs.hold_ticks} + 17'd1);
  assign rep_w      = CMP_W'({1'b0, cfg_regs.repeat_latency_ticks} + 17'd1);

  // The key that would advance: the pressed key on a press, the held key on a tick.
  assign adv_key  = (mtk_pkg::mode_t'(keys.mode) == mtk_pkg::MODE_PRESS) ? key : cur_key;
  assign adv_char = mtk_pkg::KEY_IS_CHAR[adv_key];
  assign letters  = (mtk_pkg::KEY_LEN[adv_key] > 4'(MAX_LETTERS)) ? 4'(MAX_LETTERS)
                                                                  : mtk_pkg::KEY_LEN[adv_key];
  assign tap_inc  = {1'b0, tap + 3'd1};
  assign tap_adv  = (tap_inc >= letters) ? 3'd0 : tap_inc[2:0];

  assign fire      = held && (until_fire == TIME_BITS'(1));
  assign locked    = (since_w < CMP_W'({cfg_regs.debounce_ticks, 1'b0})) || held
                     || (int'(keys.key_row) >= ROWS) || (int'(keys.key_col) >= COLS);
  assign multi_tap = adv_char && rel_valid && (rel_key == key)
                     && (since_w < CMP_W'(cfg_regs.double_tap_ticks));

  always_comb begin
    since_rel_next  = since_rel;
    until_fire_next = until_fire;
    held_next       = held;
    cur_key_next    = cur_key;
    rel_valid_next  = rel_valid;
    rel_key_next    = rel_key;
    tap_next        = tap;
    q_push.valid    = 1'b0;
    q_push.job.two  = 1'b0;
    q_push.job.press = 1'b1;
    rom_key         = adv_key;
    rom_idx         = tap;
    case (mtk_pkg::mode_t'(keys.mode))
      mtk_pkg::MODE_TICK: begin
        since_rel_next  = since_rel + TIME_BITS'(1);
        until_fire_next = until_fire - TIME_BITS'(1);
        if (fire) begin
          if (adv_char) begin
            tap_next       = tap_adv;
            rom_idx        = tap_adv;
            q_push.job.two = 1'b1;
          end
          until_fire_next = rep_w[TIME_BITS-1:0];
          q_push.valid    = 1'b1;
        end
      end
      mtk_pkg::MODE_PRESS: begin
        if (!locked) begin
          held_next       = 1'b1;
          cur_key_next    = key;
          tap_next        = multi_tap ? tap_adv : 3'd0;
          rom_idx         = multi_tap ? tap_adv : 3'd0;
          q_push.job.two  = multi_tap;
          until_fire_next = hold_w[TIME_BITS-1:0];
          q_push.valid    = 1'b1;
        end
      end
      mtk_pkg::MODE_RELEASE: begin
        if (held) begin
          held_next        = 1'b0;
          rel_valid_next   = 1'b1;
          rel_key_next     = cur_key;
          since_rel_next   = '0;
          rom_idx          = 3'd0;
          q_push.job.press = 1'b0;
          q_push.valid     = 1'b1;
        end
      end
      default: begin
      end
    endcase
    q_push.job.code = mtk_pkg::KEY_ROM[rom_key][rom_idx];
    if (!accept) begin
      q_push.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      since_rel  <= '0;
      until_fire <= '0;
      held       <= 1'b0;
      cur_key    <= '0;
      rel_valid  <= 1'b0;
      rel_key    <= '0;
      tap        <= '0;
    end else if (accept) begin
      since_rel  <= since_rel_next;
      until_fire <= until_fire_next;
      held       <= held_next;
      cur_key    <= cur_key_next;
      rel_valid  <= rel_valid_next;
      rel_key    <= rel_key_next;
      tap        <= tap_next;
    end
  end

endmodule

// ===== hdl/mtk_queue.sv =====
module mtk_queue (
  input  logic             clk,
  input  logic             rst,
  input  mtk_pkg::q_push_t q_push,
  input  logic             pop,
  output mtk_pkg::q_stat_t q_stat
);

  mtk_pkg::job_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_pop;

  assign do_pop       = pop && (count != 2'd0);
  assign q_stat.valid = (count != 2'd0);
  assign q_stat.full  = (count == 2'd2);
  assign q_stat.job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      entries[wr_ptr] <= q_push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (q_push.valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, q_push.valid} - {1'b0, do_pop};
    end
  end

endmodule

// ===== hdl/mtk_back.sv =====
module mtk_back (
  input  logic             clk,
  input  logic             rst,
  input  mtk_pkg::q_stat_t q_stat,
  output logic             pop,
  mtk_out_if.source        msgs
);

  logic       load;
  logic       pend;
  logic [7:0] pend_code;

  // Load the output register when it is empty or being taken.
  assign load = !msgs.valid || msgs.ready;
  assign pop  = load && !pend && q_stat.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      msgs.valid       <= 1'b0;
      pend             <= 1'b0;
      pend_code        <= '0;
      msgs.key_code    <= '0;
      msgs.is_press    <= 1'b0;
      msgs.last_of_run <= 1'b0;
    end else if (load) begin
      if (pend) begin
        msgs.valid       <= 1'b1;
        msgs.key_code    <= pend_code;
        msgs.is_press    <= 1'b1;
        msgs.last_of_run <= 1'b1;
        pend             <= 1'b0;
      end else if (q_stat.valid) begin
        msgs.valid <= 1'b1;
        if (q_stat.job.two) begin
          msgs.key_code    <= mtk_pkg::BACKSPACE_CODE;
          msgs.is_press    <= 1'b1;
          msgs.last_of_run <= 1'b0;
          pend             <= 1'b1;
          pend_code        <= q_stat.job.code;
        end else begin
          msgs.key_code    <= q_stat.job.code;
          msgs.is_press    <= q_stat.job.press;
          msgs.last_of_run <= 1'b1;
        end
      end else begin
        msgs.valid <= 1'b0;
      end
    end
  end

endmodule
